// ===== hw/rtl/med_float_xor_predictor_defines.svh =====
// Assertion macros shared by the predictor RTL.
// Each macro expands to one labeled concurrent assertion clocked on i_clk.
`ifndef MED_FLOAT_XOR_PREDICTOR_DEFINES_SVH
`define MED_FLOAT_XOR_PREDICTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MFXP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MFXP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/mfxp_pkg.sv =====
// Shared constants and types for the MED float XOR predictor.
// No dependencies; imported by the adder and the top level.
package mfxp_pkg;

    // Row store geometry.
    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 16;
    localparam int WORD_W    = 32;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IMG_W_W    = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_DECODE_MODE  = 2'd2
    } t_cfg_idx;

    // Canonical quiet NaN produced by an invalid addition.
    localparam logic [WORD_W-1:0] CANON_NAN = 32'h7FC0_0000;

    // Request into the float adder.
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } t_fadd_req;

endpackage

// ===== hw/rtl/mfxp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mfxp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/mfxp_fadd.sv =====
// Two-stage IEEE single-precision adder, round to nearest even.
// Depends on mfxp_pkg; stage one aligns, stage two adds, normalizes and rounds.
module mfxp_fadd import mfxp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_fadd_req         i_req,
    output logic              o_valid,
    output logic [WORD_W-1:0] o_sum
);

    // Stage one registers.
    logic        r_s1_valid;
    logic        r_s1_special;
    logic [31:0] r_s1_spec_val;
    logic        r_s1_sign;
    logic        r_s1_sub;
    logic [7:0]  r_s1_exp;
    logic [26:0] r_s1_ma;
    logic [26:0] r_s1_mb;

    // Stage two registers.
    logic        r_valid;
    logic [31:0] r_sum;

    // Stage one: special operands, magnitude swap and alignment.
    logic        a_nan, b_nan, a_inf, b_inf;
    logic        n_special;
    logic [31:0] n_spec_val;
    logic        a_ge;
    logic [31:0] big, sml;
    logic [7:0]  big_e, sml_e, diff;
    logic [26:0] big_m, sml_m, sml_sh;
    logic        sml_st;

    always_comb begin
        a_nan = (&i_req.a[30:23]) && (|i_req.a[22:0]);
        b_nan = (&i_req.b[30:23]) && (|i_req.b[22:0]);
        a_inf = (&i_req.a[30:23]) && !(|i_req.a[22:0]);
        b_inf = (&i_req.b[30:23]) && !(|i_req.b[22:0]);
        n_special = a_nan || b_nan || a_inf || b_inf;
        if (a_nan || b_nan || (a_inf && b_inf && (i_req.a[31] != i_req.b[31]))) begin
            n_spec_val = CANON_NAN;
        end else if (a_inf) begin
            n_spec_val = i_req.a;
        end else begin
            n_spec_val = i_req.b;
        end

        a_ge  = i_req.a[30:0] >= i_req.b[30:0];
        big   = a_ge ? i_req.a : i_req.b;
        sml   = a_ge ? i_req.b : i_req.a;
        big_e = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        sml_e = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        diff  = big_e - sml_e;
        big_m = {(big[30:23] != 8'd0), big[22:0], 3'b000};
        sml_m = {(sml[30:23] != 8'd0), sml[22:0], 3'b000};

        // Bits shifted out below the round bit collapse into the sticky bit.
        if (diff >= 8'd27) begin
            sml_sh = '0;
            sml_st = |sml_m;
        end else begin
            sml_sh = sml_m >> diff[4:0];
            sml_st = |(sml_m & ~({27{1'b1}} << diff[4:0]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_req.valid;
        end
        if (i_req.valid) begin
            r_s1_special  <= n_special;
            r_s1_spec_val <= n_spec_val;
            r_s1_sign     <= big[31];
            r_s1_sub      <= i_req.a[31] ^ i_req.b[31];
            r_s1_exp      <= big_e;
            r_s1_ma       <= big_m;
            r_s1_mb       <= {sml_sh[26:1], sml_sh[0] | sml_st};
        end
    end

    // Stage two: add, normalize and round.
    logic [27:0] sum28;
    logic [4:0]  lz;
    logic [8:0]  lim;
    logic [4:0]  shamt;
    logic [26:0] m27;
    logic [8:0]  e2, e3;
    logic [24:0] r25;
    logic        rnd_up;
    logic [31:0] n_sum;

    always_comb begin
        sum28 = r_s1_sub ? ({1'b0, r_s1_ma} - {1'b0, r_s1_mb})
                         : ({1'b0, r_s1_ma} + {1'b0, r_s1_mb});
        lz = 5'd27;
        for (int i = 0; i < 27; i++) begin
            if (sum28[i]) begin
                lz = 5'(26 - i);
            end
        end
        lim = {1'b0, r_s1_exp} - 9'd1;

        // A carry shifts right; otherwise shift left, stopping at the subnormal exponent.
        if (sum28[27]) begin
            shamt = '0;
            m27   = {sum28[27:2], sum28[1] | sum28[0]};
            e2    = {1'b0, r_s1_exp} + 9'd1;
        end else begin
            shamt = ({4'd0, lz} < lim) ? lz : lim[4:0];
            m27   = sum28[26:0] << shamt;
            e2    = {1'b0, r_s1_exp} - {4'd0, shamt};
        end

        rnd_up = m27[2] && (m27[1] || m27[0] || m27[3]);
        r25    = {1'b0, m27[26:3]} + {24'd0, rnd_up};
        e3     = r25[24] ? (e2 + 9'd1) : e2;

        if (r_s1_special) begin
            n_sum = r_s1_spec_val;
        end else if (sum28 == 28'd0) begin
            n_sum = {r_s1_sign & ~r_s1_sub, 31'd0};
        end else if (e3 >= 9'd255) begin
            n_sum = {r_s1_sign, 8'hFF, 23'd0};
        end else if (r25[24]) begin
            n_sum = {r_s1_sign, e3[7:0], 23'd0};
        end else if (r25[23]) begin
            n_sum = {r_s1_sign, e3[7:0], r25[22:0]};
        end else begin
            n_sum = {r_s1_sign, 8'd0, r25[22:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_s1_valid;
        end
        if (r_s1_valid) begin
            r_sum <= n_sum;
        end
    end

    assign o_valid = r_valid;
    assign o_sum   = r_sum;

endmodule

// ===== hw/rtl/med_float_xor_predictor.sv =====
// MED float XOR predictor: usage notes.
// Channels: the input channel (i_in_valid / o_in_ready) carries one 32-bit item,
// a float bit pattern when encoding or a residual when decoding, in raster
// order. The output channel (o_out_valid / i_out_ready) returns one item per
// input: the XOR of the input with the prediction, and o_plane_last on the
// last pixel of a plane. The configuration channel (i_cfg_valid / o_cfg_ready)
// writes image width, image height and decode mode; write it only while idle.
// An item goes from the input buffer through IDLE, LOOK and DONE to the output
// register for a boundary value or selected neighbor, and also through SUM, DIF1
// and DIF2 when the median falls through to N + W - NW. An item starts only after
// the last one's row store read-modify-write and the two passes through the shared
// two-stage float adder end, since each pixel is the next item's west neighbor.
// A one-item input buffer accepts the next item while the current one works,
// and the output register holds a finished item while the receiver stalls;
// the sequencer then waits with its result until the output register frees.
// Reset clears the counters, the handshake state and the registers to width 1,
// height 1, encode mode. The row store is not cleared; rows are written before
// they are read.
`include "med_float_xor_predictor_defines.svh"

module med_float_xor_predictor import mfxp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [WORD_W-1:0]     i_data_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [WORD_W-1:0]     o_result_word,
    output logic                  o_plane_last,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_SUM,
        S_DIF1,
        S_DIF2,
        S_DONE
    } t_state;

    // Float ordering helpers; plus and minus zero compare equal, and any
    // comparison with a NaN is false.
    function automatic logic [31:0] f_key(input logic [31:0] x);
        f_key = x[31] ? ~x : {1'b1, x[30:0]};
    endfunction

    function automatic logic f_nan(input logic [31:0] x);
        f_nan = (&x[30:23]) && (|x[22:0]);
    endfunction

    function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
        f_lt = !f_nan(a) && !f_nan(b)
            && !((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) && (f_key(a) < f_key(b));
    endfunction

    function automatic logic f_le(input logic [31:0] a, input logic [31:0] b);
        f_le = !f_nan(a) && !f_nan(b)
            && (((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) || (f_key(a) <= f_key(b)));
    endfunction

    t_state             r_state;
    logic [COL_W-1:0]   r_wlast;
    logic [ROW_W-1:0]   r_hlast;
    logic               r_decode;
    logic               r_buf_valid;
    logic [WORD_W-1:0]  r_buf_data;
    logic [WORD_W-1:0]  r_data;
    logic [WORD_W-1:0]  r_west;
    logic [WORD_W-1:0]  r_nwest;
    logic [WORD_W-1:0]  r_north;
    logic [WORD_W-1:0]  r_pred;
    logic               r_use_add;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_word;
    logic               r_out_last;

    logic [WORD_W-1:0]  ram_rdata;
    logic               ram_re;
    logic               ram_we;
    logic [WORD_W-1:0]  pixel;
    logic [WORD_W-1:0]  pred;
    logic               slot_free;
    logic               finish;
    logic               row_end;
    logic               plane_end;
    t_fadd_req          fadd_req;
    logic               fadd_valid;
    logic [WORD_W-1:0]  fadd_sum;

    // Median edge detector decision on the neighbors.
    logic               n_lt_w, w_lt_n;
    logic [WORD_W-1:0]  mx_b, mn_b;
    logic               sel_mn, sel_mx;
    logic [COL_W:0]     wlast_calc;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_buf_valid;
    assign slot_free   = !r_out_valid || i_out_ready;
    assign finish      = (r_state == S_DONE) && slot_free;
    assign ram_re      = (r_state == S_IDLE) && r_buf_valid;
    assign ram_we      = finish;

    always_comb begin
        n_lt_w = f_lt(ram_rdata, r_west);
        w_lt_n = f_lt(r_west, ram_rdata);
        mx_b   = n_lt_w ? r_west : ram_rdata;
        mn_b   = w_lt_n ? r_west : ram_rdata;
        sel_mn = f_le(mx_b, r_nwest);
        sel_mx = f_le(r_nwest, mn_b);
    end

    // Final prediction, pixel for the store, and row and plane ends.
    assign pred      = r_use_add ? fadd_sum : r_pred;
    assign pixel     = r_decode ? (r_data ^ pred) : r_data;
    assign row_end   = r_col >= r_wlast;
    assign plane_end = row_end && (r_row >= r_hlast);

    // Adder requests: N + W first, then the sum minus NW.
    always_comb begin
        fadd_req.valid = 1'b0;
        fadd_req.a     = ram_rdata;
        fadd_req.b     = r_west;
        if ((r_state == S_LOOK) && (r_row != '0) && (r_col != '0) && !sel_mn && !sel_mx) begin
            fadd_req.valid = 1'b1;
        end else if (r_state == S_DIF1) begin
            fadd_req.valid = 1'b1;
            fadd_req.a     = fadd_sum;
            fadd_req.b     = {~r_nwest[31], r_nwest[30:0]};
        end
    end

    // Clamped last column for a width write.
    always_comb begin
        wlast_calc = '0;
        if (i_cfg_data[IMG_W_W-1:0] > IMG_W_W'(MAX_WIDTH)) begin
            wlast_calc = (COL_W+1)'(MAX_WIDTH - 1);
        end else if (i_cfg_data[IMG_W_W-1:0] != '0) begin
            wlast_calc = (COL_W+1)'(i_cfg_data[IMG_W_W-1:0] - IMG_W_W'(1));
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlast  <= '0;
            r_hlast  <= '0;
            r_decode <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH: begin
                    r_wlast <= wlast_calc[COL_W-1:0];
                end
                CFG_IMAGE_HEIGHT: begin
                    r_hlast <= (i_cfg_data == '0) ? '0 : (i_cfg_data - CFG_DATA_W'(1));
                end
                CFG_DECODE_MODE: begin
                    r_decode <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Input buffer: takes the next item while the current one is in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_buf_valid <= 1'b1;
        end else if (ram_re) begin
            r_buf_valid <= 1'b0;
        end
        if (i_in_valid && o_in_ready) begin
            r_buf_data <= i_data_word;
        end
    end

    // Sequencer, neighbor registers, counters and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready && !finish) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (r_buf_valid) begin
                        r_data  <= r_buf_data;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_north   <= ram_rdata;
                    r_use_add <= 1'b0;
                    r_state   <= S_DONE;
                    if ((r_row == '0) && (r_col == '0)) begin
                        r_pred <= '0;
                    end else if (r_row == '0) begin
                        r_pred <= r_west;
                    end else if (r_col == '0) begin
                        r_pred <= ram_rdata;
                    end else if (sel_mn) begin
                        r_pred <= mn_b;
                    end else if (sel_mx) begin
                        r_pred <= mx_b;
                    end else begin
                        r_use_add <= 1'b1;
                        r_state   <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_state <= S_DIF1;
                end
                S_DIF1: begin
                    r_state <= S_DIF2;
                end
                S_DIF2: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (slot_free) begin
                        r_west      <= pixel;
                        r_nwest     <= r_north;
                        r_out_valid <= 1'b1;
                        r_out_word  <= r_data ^ pred;
                        r_out_last  <= plane_end;
                        r_state     <= S_IDLE;
                        if (plane_end) begin
                            r_col <= '0;
                            r_row <= '0;
                        end else if (row_end) begin
                            r_col <= '0;
                            r_row <= r_row + ROW_W'(1);
                        end else begin
                            r_col <= r_col + COL_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_word = r_out_word;
    assign o_plane_last  = r_out_last;

    // Row store: read at item start, written back when the item finishes.
    mfxp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_col),
        .i_wdata (pixel),
        .i_re    (ram_re),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // Shared float adder for both median additions.
    mfxp_fadd u_fadd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fadd_req),
        .o_valid (fadd_valid),
        .o_sum   (fadd_sum)
    );

    // The interlock never lets a store read and write-back meet in one cycle.
    `MFXP_ASSERT_NOW(a_no_rw_overlap, ram_we, !ram_re)
    // Adder results arrive exactly where the sequencer consumes them.
    `MFXP_ASSERT_NOW(a_fadd_timing, fadd_valid, (r_state == S_DIF1) || (r_state == S_DONE))
    // A plane end returns both counters to the origin.
    `MFXP_ASSERT_NEXT(a_plane_restart, finish && plane_end, (r_col == '0) && (r_row == '0))
    // A finished item always lands in the output register.
    `MFXP_ASSERT_NEXT(a_finish_loads_out, finish, o_out_valid && (r_state == S_IDLE))

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the MED float XOR predictor.
// Depends on mfxp_pkg and the med_float_xor_predictor RTL; runs standalone.
`timescale 1ns / 1ps

module testbench;
    import mfxp_pkg::*;

    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int MAX_GAP      = 18;
    localparam int MAX_MSGS     = 10;
    localparam int RANDOM_ITEMS = 1300;
    localparam int TAIL_ITEMS   = 200;
    // The configuration index that no register uses.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic              last;
    } t_pixel_result;

    // One row of the directed table: a register write or an item.
    typedef struct {
        bit                    is_reg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        logic [WORD_W-1:0]     word;
        bit                    typed;
        logic [WORD_W-1:0]     exp_word;
        logic                  exp_last;
    } t_directed_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [WORD_W-1:0]     i_data_word = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [WORD_W-1:0]     o_result_word;
    logic                  o_plane_last;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    med_float_xor_predictor i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_word   (i_data_word),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_word (o_result_word),
        .o_plane_last  (o_plane_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predictor state: configuration, row store, neighbors and position.
    logic [IMG_W_W-1:0] cfg_width = 13'd1;
    logic [ROW_W-1:0]   cfg_height = 16'd1;
    logic               cfg_decode = 1'b0;
    logic [WORD_W-1:0]  row_above [MAX_WIDTH];
    logic [WORD_W-1:0]  west_pix = '0;
    logic [WORD_W-1:0]  north_west_pix = '0;
    int                 col_pos = 0;
    int                 row_pos = 0;

    t_pixel_result      pending_results[$];
    t_directed_row      directed_rows[$];
    int                 mismatches = 0;
    int                 cycles = 0;
    bit                 no_idle = 1'b0;
    int                 out_stall = 0;

    function automatic bit f32_is_nan(logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] != 0;
    endfunction

    // Maps float bits to an unsigned key in numeric order; both zeros meet.
    function automatic logic [31:0] f32_order_key(logic [31:0] x);
        if (x[30:0] == 0)
            return 32'h8000_0000;
        return x[31] ? ~x : (x | 32'h8000_0000);
    endfunction

    function automatic bit f32_lt(logic [31:0] a, logic [31:0] b);
        return !f32_is_nan(a) && !f32_is_nan(b) && f32_order_key(a) < f32_order_key(b);
    endfunction

    function automatic bit f32_le(logic [31:0] a, logic [31:0] b);
        return !f32_is_nan(a) && !f32_is_nan(b) && f32_order_key(a) <= f32_order_key(b);
    endfunction

    // Single-precision addition, round to nearest even, NaN made canonical.
    function automatic logic [31:0] f32_add(logic [31:0] a, logic [31:0] b);
        logic [31:0] t;
        logic [27:0] x;
        logic [27:0] y;
        logic [27:0] r;
        logic [24:0] m;
        logic        s;
        logic        up;
        int          ea;
        int          eb;
        int          e;
        int          d;
        if (f32_is_nan(a) || f32_is_nan(b))
            return CANON_NAN;
        if (a[30:23] == 8'hFF && b[30:23] == 8'hFF)
            return (a[31] != b[31]) ? CANON_NAN : a;
        if (a[30:23] == 8'hFF)
            return a;
        if (b[30:23] == 8'hFF)
            return b;
        if (a[30:0] == 0 && b[30:0] == 0)
            return {a[31] & b[31], 31'b0};
        if (b[30:0] > a[30:0]) begin
            t = a;
            a = b;
            b = t;
        end
        s = a[31];
        ea = a[30:23];
        eb = b[30:23];
        x = {1'b0, ea != 0, a[22:0], 3'b0};
        y = {1'b0, eb != 0, b[22:0], 3'b0};
        if (ea == 0) ea = 1;
        if (eb == 0) eb = 1;
        d = ea - eb;
        if (d > 26)
            y = (y != 0) ? 28'd1 : 28'd0;
        else if (d > 0)
            y = (y >> d) | ((y & ((28'd1 << d) - 28'd1)) != 0);
        r = (a[31] == b[31]) ? x + y : x - y;
        if (r == 0)
            return 32'h0;
        e = ea;
        if (r[27]) begin
            r = (r >> 1) | r[0];
            e++;
        end else begin
            while (!r[26] && e > 1) begin
                r = r << 1;
                e--;
            end
        end
        up = r[2] && (r[1] || r[0] || r[3]);
        m = {1'b0, r[26:3]} + up;
        if (m[24]) begin
            m = m >> 1;
            e++;
        end
        if (e >= 255)
            return {s, 8'hFF, 23'b0};
        if (!m[23])
            e = 0;
        return {s, e[7:0], m[22:0]};
    endfunction

    // Median edge detector on the west, north and north-west neighbors.
    function automatic logic [31:0] med_estimate(logic [31:0] w, logic [31:0] n,
                                                 logic [31:0] nw);
        logic [31:0] hi;
        logic [31:0] lo;
        hi = f32_lt(n, w) ? w : n;
        lo = f32_lt(w, n) ? w : n;
        if (f32_le(hi, nw))
            return lo;
        if (f32_le(nw, lo))
            return hi;
        return f32_add(f32_add(n, w), nw ^ 32'h8000_0000);
    endfunction

    // Works out the result of one accepted item and advances the state.
    function automatic t_pixel_result predict_pixel(logic [31:0] data);
        t_pixel_result res;
        logic [31:0]   north;
        logic [31:0]   guess;
        logic [31:0]   pixel;
        int            w;
        int            h;
        int            idx;
        bit            row_done;
        w = cfg_width;
        h = cfg_height;
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (h == 0) h = 1;
        idx = (col_pos < MAX_WIDTH) ? col_pos : MAX_WIDTH - 1;
        north = row_above[idx];
        if (row_pos == 0 && col_pos == 0)
            guess = '0;
        else if (row_pos == 0)
            guess = west_pix;
        else if (col_pos == 0)
            guess = north;
        else
            guess = med_estimate(west_pix, north, north_west_pix);
        pixel = cfg_decode ? (data ^ guess) : data;
        res.word = data ^ guess;
        row_above[idx] = pixel;
        north_west_pix = north;
        west_pix = pixel;
        row_done = col_pos >= w - 1;
        res.last = row_done && row_pos >= h - 1;
        if (res.last) begin
            col_pos = 0;
            row_pos = 0;
        end else if (row_done) begin
            col_pos = 0;
            row_pos++;
        end else begin
            col_pos++;
        end
        return res;
    endfunction

    // Sends one item after a random gap (none while no_idle is set); returns at the
    // falling edge after it is taken. A typed expectation overrides the predicted one.
    task automatic send_pixel(logic [31:0] data, bit typed = 0,
                              logic [31:0] exp_word = '0, logic exp_last = 0);
        t_pixel_result res;
        int            gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_word <= data;
        do @(posedge i_clk); while (!o_in_ready);
        res = predict_pixel(data);
        if (typed) begin
            res.word = exp_word;
            res.last = exp_last;
        end
        pending_results.push_back(res);
        @(negedge i_clk);
    endtask

    // Writes a register once the block has drained.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_IMAGE_WIDTH:  cfg_width = val[IMG_W_W-1:0];
            CFG_IMAGE_HEIGHT: cfg_height = val;
            CFG_DECODE_MODE:  cfg_decode = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Pixel words: mostly a smooth positive image when encoding, small
    // residuals when decoding, with signed floats and raw bits mixed in.
    function automatic logic [31:0] pick_word();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            if (cfg_decode)
                return $urandom_range(0, 65535);
            return {1'b0, 8'($urandom_range(124, 130)), 23'($urandom)};
        end
        if (pick < 8)
            return {1'($urandom), 8'($urandom_range(0, 254)), 23'($urandom)};
        return $urandom;
    endfunction

    task automatic add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        t_directed_row row;
        row = '{1'b1, idx, val, '0, 1'b0, '0, 1'b0};
        directed_rows.push_back(row);
    endtask

    task automatic add_pixel(logic [31:0] word, bit typed = 0,
                             logic [31:0] exp_word = '0, logic exp_last = 0);
        t_directed_row row;
        row = '{1'b0, CFG_IMAGE_WIDTH, '0, word, typed, exp_word, exp_last};
        directed_rows.push_back(row);
    endtask

    // Result stall: a fresh draw for every item taken.
    always @(negedge i_clk) begin
        if (out_stall > 0) begin
            i_out_ready <= 1'b0;
            out_stall <= out_stall - 1;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare each result with the oldest expectation.
    always @(posedge i_clk) begin
        t_pixel_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            out_stall <= no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_MSGS)
                    $display("unexpected item: word %h last %b", o_result_word, o_plane_last);
            end else begin
                want = pending_results.pop_front();
                if (o_result_word !== want.word || o_plane_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_MSGS)
                        $display("mismatch: expected word %h last %b, got word %h last %b",
                                 want.word, want.last, o_result_word, o_plane_last);
                end
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int sent;
        int w;
        int h;
        int n;
        int plane;
        // After reset: one-pixel planes predict zero, so the word comes back.
        add_pixel(32'h0000_0000, 1, 32'h0000_0000, 1'b1);
        add_pixel(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1'b1);
        add_pixel(32'h7F80_0000, 1, 32'h7F80_0000, 1'b1);
        add_pixel(32'h8000_0000, 1, 32'h8000_0000, 1'b1);
        add_reg(CFG_DECODE_MODE, 16'd1);
        add_pixel(32'h1234_5678, 1, 32'h1234_5678, 1'b1);
        add_reg(CFG_DECODE_MODE, 16'd0);
        add_reg(CFG_UNUSED_IDX, 16'd5);
        // Two-wide plane with infinities and a negative zero.
        add_reg(CFG_IMAGE_WIDTH, 16'd2);
        add_reg(CFG_IMAGE_HEIGHT, 16'd3);
        add_pixel(32'h3F80_0000);
        add_pixel(32'h4000_0000);
        add_pixel(32'h4040_0000);
        add_pixel(32'h7F80_0000);
        add_pixel(32'hFF80_0000);
        add_pixel(32'h8000_0000);
        // Three-wide plane with a denormal, the largest float and a NaN.
        add_reg(CFG_IMAGE_WIDTH, 16'd3);
        add_reg(CFG_IMAGE_HEIGHT, 16'd2);
        add_pixel(32'h3F80_0000);
        add_pixel(32'h0000_0001);
        add_pixel(32'h7F7F_FFFF);
        add_pixel(32'hC000_0000);
        add_pixel(32'h7FC0_0000);
        add_pixel(32'h3F80_0000);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_reg)
                write_reg(directed_rows[i].idx, directed_rows[i].val);
            else
                send_pixel(directed_rows[i].word, directed_rows[i].typed,
                           directed_rows[i].exp_word, directed_rows[i].exp_last);
        end

        // Random phases of whole planes, so no row is read before it is written.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            w = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 70) : $urandom_range(1, 12);
            h = $urandom_range(1, 6);
            if ($urandom_range(0, 9) == 0) w = 0;
            if ($urandom_range(0, 9) == 0) h = 0;
            no_idle = ($urandom_range(0, 3) == 0);
            write_reg(CFG_IMAGE_WIDTH, 16'(w));
            write_reg(CFG_IMAGE_HEIGHT, 16'(h));
            write_reg(CFG_DECODE_MODE, 16'($urandom_range(0, 1)));
            plane = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
            n = $urandom_range(1, 3) * plane;
            // Near the end of the budget a single plane keeps the count close.
            if (sent + n > RANDOM_ITEMS)
                n = plane;
            repeat (n) send_pixel(pick_word());
            sent += n;
        end

        // Oversized width clamps to the full row store; the plane stays open.
        no_idle = 1'b0;
        write_reg(CFG_IMAGE_WIDTH, 16'd8191);
        write_reg(CFG_IMAGE_HEIGHT, 16'hFFFF);
        write_reg(CFG_DECODE_MODE, 16'd1);
        repeat (TAIL_ITEMS) send_pixel(pick_word());

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
